### rtl/mkm_pkg.sv
// Shared types and constants for the Manhattan Kruskal spanning tree unit.
package mkm_pkg;

	localparam int unsigned OPC_W   = 2;
	localparam int unsigned COORD_W = 16;

	typedef enum logic [OPC_W-1:0] {
		OP_POINT = 2'd0,
		OP_LINK  = 2'd1,
		OP_GO    = 2'd2,
		OP_NONE  = 2'd3
	} mkm_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LRA,
		S_LRB,
		S_LGB,
		S_SWRD,
		S_SWWR,
		S_GRI,
		S_GLI,
		S_GRJ,
		S_GDJ,
		S_GCMP,
		S_GEND,
		S_GOUT
	} mkm_state_t;

endpackage

### rtl/mkm_store.sv
// Point coordinate and component label memories, one write and one registered read port.
module mkm_store import mkm_pkg::*; #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned CW    = 16,
	parameter int unsigned AW    = 6
) (
	input  logic                 clk,
	input  logic                 xy_we,
	input  logic                 lab_we,
	input  logic [AW-1:0]        waddr,
	input  logic signed [CW-1:0] wx,
	input  logic signed [CW-1:0] wy,
	input  logic [AW-1:0]        wlab,
	input  logic [AW-1:0]        raddr,
	output logic signed [CW-1:0] rx,
	output logic signed [CW-1:0] ry,
	output logic [AW-1:0]        rlab
);

	logic signed [CW-1:0] x_mem [DEPTH];
	logic signed [CW-1:0] y_mem [DEPTH];
	logic [AW-1:0]        lab_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (xy_we) begin
			x_mem[waddr] <= wx;
			y_mem[waddr] <= wy;
		end
		if (lab_we) begin
			lab_mem[waddr] <= wlab;
		end
		rx   <= x_mem[raddr];
		ry   <= y_mem[raddr];
		rlab <= lab_mem[raddr];
	end

endmodule

### rtl/mkm_dist.sv
// Manhattan distance unit: registered absolute differences, then their sum.
module mkm_dist import mkm_pkg::*; #(
	parameter int unsigned CW = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] xa,
	input  logic signed [CW-1:0] ya,
	input  logic signed [CW-1:0] xb,
	input  logic signed [CW-1:0] yb,
	output logic [CW:0]          mdist
);

	logic signed [CW:0] dx, dy;
	logic [CW-1:0]      adx_q, ady_q;

	always_comb begin
		dx = {xa[CW-1], xa} - {xb[CW-1], xb};
		dy = {ya[CW-1], ya} - {yb[CW-1], yb};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adx_q <= dx[CW] ? CW'(-dx) : dx[CW-1:0];
			ady_q <= dy[CW] ? CW'(-dy) : dy[CW-1:0];
		end
	end

	assign mdist = {1'b0, adx_q} + {1'b0, ady_q};

endmodule

### rtl/manhattan_kruskal_mst_unit.sv
// Top level: sequencer for point/link loading and the Kruskal edge scan.
//
//  channel | signals                                  | direction
//  input   | in_valid/in_ready, opcode, coord_x/y,    | in
//          | link_a, link_b                           |
//  output  | out_valid/out_ready, edge_from, edge_to, | out
//          | no_edge, last                            |
//
// Sequence: a point is written in the cycle it is accepted; an in-range link reads both
// labels, then relabels every point when it joins two components. A go runs one scan
// pass per merge: a row read per point, a read, distance and compare per point pair and
// a closing step, then a relabel of every point, all through the single memory read port.
// Reset clears the sequencer and point count; memories need no clearing.
// The block takes no item during a go, and each result holds it until out_ready.
module manhattan_kruskal_mst_unit import mkm_pkg::*; #(
	parameter int unsigned MAX_POINTS = 64,
	parameter int unsigned COORD_BITS = 16,
	localparam int unsigned IDXW      = $clog2(MAX_POINTS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OPC_W-1:0]     opcode,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic [IDXW-1:0]      link_a,
	input  logic [IDXW-1:0]      link_b,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [IDXW-1:0]      edge_from,
	output logic [IDXW-1:0]      edge_to,
	output logic                 no_edge,
	output logic                 last
);

	localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned CW = COORD_BITS;

	mkm_state_t state_q, state_d;

	logic [IDXW-1:0] cnt_q, k_q, i_q, j_q, bi_q, bj_q, pf_q, pt_q;
	logic [AW-1:0]   la_q, lb_q, li_q, lj_q, bli_q, blj_q;
	logic signed [CW-1:0] xi_q, yi_q;
	logic [CW:0]     best_q;
	logic            found_q, same_q, pend_q, go_q, fin_q;
	logic            ov_q, none_q, last_q;
	logic [IDXW-1:0] ef_q, et_q;

	logic                 xy_we, lab_we;
	logic [AW-1:0]        waddr, wlab, raddr;
	logic signed [CW-1:0] rx, ry;
	logic [AW-1:0]        rlab;
	logic [CW:0]          pair_dist;
	logic                 dist_en;
	logic                 acc;
	mkm_op_t              op;

	assign op  = mkm_op_t'(opcode);
	assign acc = in_valid && in_ready;

	mkm_store #(.DEPTH(MAX_POINTS), .CW(CW), .AW(AW)) u_store (
		.clk(clk), .xy_we(xy_we), .lab_we(lab_we), .waddr(waddr),
		.wx(coord_x[CW-1:0]), .wy(coord_y[CW-1:0]), .wlab(wlab),
		.raddr(raddr), .rx(rx), .ry(ry), .rlab(rlab)
	);

	mkm_dist #(.CW(CW)) u_dist (
		.clk(clk), .en(dist_en), .xa(xi_q), .ya(yi_q), .xb(rx), .yb(ry),
		.mdist(pair_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = (state_q == S_IDLE);
		xy_we    = 1'b0;
		lab_we   = 1'b0;
		waddr    = k_q[AW-1:0];
		wlab     = lb_q;
		raddr    = k_q[AW-1:0];
		dist_en  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (acc && op == OP_POINT && cnt_q < IDXW'(MAX_POINTS)) begin
					xy_we  = 1'b1;
					lab_we = 1'b1;
					waddr  = cnt_q[AW-1:0];
					wlab   = cnt_q[AW-1:0];
				end
				if (acc && op == OP_LINK && link_a != '0 && link_a <= cnt_q
						&& link_b != '0 && link_b <= cnt_q) begin
					state_d = S_LRA;
				end
				if (acc && op == OP_GO) begin
					state_d = (cnt_q < IDXW'(2)) ? S_GEND : S_GRI;
				end
			end
			S_LRA: begin
				raddr   = i_q[AW-1:0];
				state_d = S_LRB;
			end
			S_LRB: begin
				raddr   = j_q[AW-1:0];
				state_d = S_LGB;
			end
			S_LGB: begin
				state_d = (la_q == rlab) ? S_IDLE : S_SWRD;
			end
			S_SWRD: begin
				state_d = S_SWWR;
			end
			S_SWWR: begin
				lab_we = (rlab == la_q);
				if (k_q + IDXW'(1) < cnt_q) begin
					state_d = S_SWRD;
				end else if (!go_q) begin
					state_d = S_IDLE;
				end else if (best_q != '0 && pend_q) begin
					state_d = S_GOUT;
				end else begin
					state_d = S_GRI;
				end
			end
			S_GRI: begin
				raddr   = i_q[AW-1:0];
				state_d = S_GLI;
			end
			S_GLI: begin
				state_d = S_GRJ;
			end
			S_GRJ: begin
				raddr   = j_q[AW-1:0];
				state_d = S_GDJ;
			end
			S_GDJ: begin
				dist_en = 1'b1;
				state_d = S_GCMP;
			end
			S_GCMP: begin
				if (j_q + IDXW'(1) < cnt_q) begin
					state_d = S_GRJ;
				end else if (i_q + IDXW'(2) < cnt_q) begin
					state_d = S_GRI;
				end else begin
					state_d = S_GEND;
				end
			end
			S_GEND: begin
				state_d = found_q ? S_SWRD : S_GOUT;
			end
			S_GOUT: begin
				if (out_ready) begin
					state_d = fin_q ? S_IDLE : S_GRI;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ov_q    <= 1'b0;
			found_q <= 1'b0;
			pend_q  <= 1'b0;
			go_q    <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc && op == OP_POINT && cnt_q < IDXW'(MAX_POINTS)) begin
						cnt_q <= cnt_q + IDXW'(1);
					end
					i_q     <= link_a - IDXW'(1);
					j_q     <= link_b - IDXW'(1);
					k_q     <= '0;
					go_q    <= 1'b0;
					found_q <= 1'b0;
					pend_q  <= 1'b0;
					if (acc && op == OP_GO) begin
						go_q <= 1'b1;
						i_q  <= '0;
					end
				end
				S_LRB: la_q <= rlab;
				S_LGB: lb_q <= rlab;
				S_SWRD: ;
				S_SWWR: begin
					k_q <= k_q + IDXW'(1);
					if (k_q + IDXW'(1) >= cnt_q && go_q) begin
						// merge done: restart the scan, retiring the held edge if needed
						i_q     <= '0;
						found_q <= 1'b0;
						if (best_q != '0) begin
							pend_q <= 1'b1;
							pf_q   <= bi_q + IDXW'(1);
							pt_q   <= bj_q + IDXW'(1);
							if (pend_q) begin
								ov_q   <= 1'b1;
								ef_q   <= pf_q;
								et_q   <= pt_q;
								none_q <= 1'b0;
								last_q <= 1'b0;
								fin_q  <= 1'b0;
							end
						end
					end
				end
				S_GRI: ;
				S_GLI: begin
					xi_q <= rx;
					yi_q <= ry;
					li_q <= rlab;
					j_q  <= i_q + IDXW'(1);
				end
				S_GRJ: ;
				S_GDJ: begin
					same_q <= (rlab == li_q);
					lj_q   <= rlab;
				end
				S_GCMP: begin
					if (!same_q && (!found_q || pair_dist < best_q)) begin
						found_q <= 1'b1;
						best_q  <= pair_dist;
						bi_q    <= i_q;
						bj_q    <= j_q;
						bli_q   <= li_q;
						blj_q   <= lj_q;
					end
					if (j_q + IDXW'(1) < cnt_q) begin
						j_q <= j_q + IDXW'(1);
					end else begin
						i_q <= i_q + IDXW'(1);
					end
				end
				S_GEND: begin
					if (found_q) begin
						la_q <= bli_q;
						lb_q <= blj_q;
						k_q  <= '0;
					end else begin
						ov_q   <= 1'b1;
						ef_q   <= pend_q ? pf_q : '0;
						et_q   <= pend_q ? pt_q : '0;
						none_q <= !pend_q;
						last_q <= 1'b1;
						fin_q  <= 1'b1;
						cnt_q  <= '0;
					end
				end
				S_GOUT: begin
					if (out_ready) begin
						ov_q    <= 1'b0;
						i_q     <= '0;
						found_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign edge_from = ef_q;
	assign edge_to   = et_q;
	assign no_edge   = none_q;
	assign last      = last_q;

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while a result waits");
	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_edge) |-> last) else $error("empty result not final");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= IDXW'(MAX_POINTS)) else $error("point count overflow");
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && opcode == OP_GO) |=> !in_ready)
		else $error("go transaction did not start a run");

endmodule

### verif/tb_manhattan_kruskal_mst_unit.sv
// Testbench for the Manhattan Kruskal spanning tree unit: directed and random stimulus, scoreboard.
module tb_manhattan_kruskal_mst_unit import mkm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS      = 64;
	localparam int IW        = 7;
	localparam int WDOG_MAX  = 1500000;

	typedef struct packed {
		logic [IW-1:0] from_idx;
		logic [IW-1:0] to_idx;
		logic          none;
		logic          fin;
	} tree_edge_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [OPC_W-1:0]           opcode;
	logic signed [COORD_W-1:0]  coord_x;
	logic signed [COORD_W-1:0]  coord_y;
	logic [IW-1:0]              link_a;
	logic [IW-1:0]              link_b;
	logic                       out_valid;
	logic                       out_ready;
	logic [IW-1:0]              edge_from;
	logic [IW-1:0]              edge_to;
	logic                       no_edge;
	logic                       last;

	manhattan_kruskal_mst_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.coord_x(coord_x), .coord_y(coord_y), .link_a(link_a), .link_b(link_b),
		.out_valid(out_valid), .out_ready(out_ready), .edge_from(edge_from),
		.edge_to(edge_to), .no_edge(no_edge), .last(last)
	);

	// shadow copy of the point set and union-find table
	int         pt_x [NPTS];
	int         pt_y [NPTS];
	int         uf_parent [NPTS];
	int         pt_count;
	tree_edge_t tree_q [$];

	int  n_errors;
	int  n_sent;
	bit  idle_on;
	int  rx_hold;
	int  wdog;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int uf_root(int p);
		int steps;
		steps = 0;
		while (p < NPTS && uf_parent[p] != p && steps < NPTS) begin
			p = uf_parent[p];
			steps++;
		end
		return (p < NPTS) ? p : 0;
	endfunction

	function automatic int absdiff(int a, int b);
		return (a > b) ? a - b : b - a;
	endfunction

	// compute expected tree edges for one transaction
	function automatic void predict_tree(mkm_op_t op, logic signed [15:0] x,
			logic signed [15:0] y, logic [IW-1:0] a, logic [IW-1:0] b);
		int         n, i, j, ri, d, best_d, bi, bj;
		bit         found;
		tree_edge_t e;
		n = 0;
		case (op)
			OP_POINT: begin
				if (pt_count < NPTS) begin
					pt_x[pt_count] = int'(x);
					pt_y[pt_count] = int'(y);
					uf_parent[pt_count] = pt_count;
					pt_count++;
				end
			end
			OP_LINK: begin
				if (a >= 1 && a <= pt_count && b >= 1 && b <= pt_count)
					uf_parent[uf_root(int'(a) - 1)] = uf_root(int'(b) - 1);
			end
			OP_GO: begin
				forever begin
					found = 0;
					best_d = 0;
					bi = 0;
					bj = 0;
					for (i = 0; i + 1 < pt_count; i++) begin
						ri = uf_root(i);
						for (j = i + 1; j < pt_count; j++) begin
							if (uf_root(j) == ri)
								continue;
							d = absdiff(pt_x[i], pt_x[j]) + absdiff(pt_y[i], pt_y[j]);
							if (!found || d < best_d) begin
								found = 1;
								best_d = d;
								bi = i;
								bj = j;
							end
						end
					end
					if (!found)
						break;
					uf_parent[uf_root(bi)] = uf_root(bj);
					if (best_d != 0 && n < NPTS - 1) begin
						e.from_idx = IW'(bi + 1);
						e.to_idx = IW'(bj + 1);
						e.none = 1'b0;
						e.fin = 1'b0;
						tree_q.push_back(e);
						n++;
					end
				end
				if (n == 0) begin
					e = '0;
					e.none = 1'b1;
					e.fin = 1'b1;
					tree_q.push_back(e);
				end else begin
					tree_q[tree_q.size() - 1].fin = 1'b1;
				end
				pt_count = 0;
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	// send one transaction, hold valid until accepted
	task automatic send_item(mkm_op_t op, logic [15:0] x = '0, logic [15:0] y = '0,
			logic [IW-1:0] a = '0, logic [IW-1:0] b = '0);
		int gap;
		gap = idle_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		coord_x <= x;
		coord_y <= y;
		link_a <= a;
		link_b <= b;
		do @(posedge clk); while (!in_ready);
		predict_tree(op, x, y, a, b);
		n_sent++;
	endtask

	task automatic send_point(int x, int y);
		send_item(OP_POINT, 16'(x), 16'(y));
	endtask

	task automatic send_link(int a, int b);
		send_item(OP_LINK, '0, '0, IW'(a), IW'(b));
	endtask

	// drop valid and wait until every expected edge has come, then let the block settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tree_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic test_corners();
		send_item(OP_GO);                           // empty set
		send_point(5, 5);
		send_item(OP_GO);                           // single point
		send_point(-32768, -32768);
		send_point(32767, 32767);
		send_point(0, 0);
		send_point(0, 0);                           // duplicate: zero distance
		send_point(-1, 1);
		send_link(0, 1);                            // index zero
		send_link(6, 1);                            // beyond count
		send_link(127, 127);
		send_link(3, 3);                            // self link
		send_item(OP_NONE, 16'hffff, 16'hffff, 7'h7f, 7'h7f);
		send_link(1, 2);
		send_item(OP_GO);
		// square: equal distances decide by index
		send_point(0, 0);
		send_point(1, 0);
		send_point(0, 1);
		send_point(1, 1);
		send_item(OP_GO);
		// all linked beforehand: no edge to emit
		send_point(3, 4);
		send_point(-7, 2);
		send_point(9, 9);
		send_link(1, 2);
		send_link(3, 2);
		send_item(OP_GO);
		wait_drained();
	endtask

	task automatic test_capacity();
		int i;
		for (i = 0; i < NPTS + 2; i++)
			send_point($urandom, $urandom);
		send_link(NPTS, 1);
		send_item(OP_GO);
		wait_drained();
	endtask

	// one point set with random links and mixed noise, closed by a go
	task automatic random_set(int k);
		int i, mode, nl, a, b;
		mode = $urandom_range(0, 2);
		for (i = 0; i < k; i++) begin
			if (mode == 0 || (mode == 2 && $urandom_range(0, 1)))
				send_point($urandom, $urandom);
			else
				send_point($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3);
			if ($urandom_range(0, 19) == 0)
				send_item(OP_NONE, 16'($urandom), 16'($urandom), IW'($urandom),
					IW'($urandom));
		end
		nl = $urandom_range(0, 3);
		for (i = 0; i < nl; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				a = $urandom_range(0, 127);
				b = $urandom_range(0, 127);
			end else begin
				a = $urandom_range(1, k + 1);
				b = $urandom_range(1, k + 1);
			end
			send_link(a, b);
		end
		send_item(OP_GO);
	endtask

	task automatic test_backpressure();
		rx_hold = 3000;
		random_set(6);
		random_set(5);
		random_set(4);
		wait_drained();
	endtask

	task automatic test_random();
		int target;
		target = n_sent + 165;
		while (n_sent < target) begin
			idle_on = ($urandom_range(0, 3) != 0);
			random_set(($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
				: $urandom_range(0, 9));
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	// receiver: random stalls between transactions, plus an optional long hold
	always @(posedge clk) begin
		int w;
		logic nxt;
		nxt = out_ready;
		if (rx_hold > 0) begin
			rx_hold--;
			nxt = 1'b0;
		end else if (!out_ready) begin
			nxt = 1'b1;
		end else if (out_valid) begin
			w = idle_on ? $urandom_range(0, 13) : 0;
			if (w > 0) begin
				rx_hold = w - 1;
				nxt = 1'b0;
			end
		end
		out_ready <= nxt;
	end

	// scoreboard
	always @(posedge clk) begin
		tree_edge_t want;
		if (out_valid && out_ready) begin
			if (tree_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = tree_q.pop_front();
				if (edge_from !== want.from_idx)
					report_mismatch("edge_from", edge_from, want.from_idx);
				if (edge_to !== want.to_idx)
					report_mismatch("edge_to", edge_to, want.to_idx);
				if (no_edge !== want.none)
					report_mismatch("no_edge", no_edge, want.none);
				if (last !== want.fin)
					report_mismatch("last", last, want.fin);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("** manhattan_kruskal_mst_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		opcode = OP_NONE;
		coord_x = '0;
		coord_y = '0;
		link_a = '0;
		link_b = '0;
		pt_count = 0;
		n_errors = 0;
		n_sent = 0;
		idle_on = 1'b1;
		rx_hold = 0;
		wdog = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		idle_on = 1'b0;
		test_capacity();
		idle_on = 1'b1;
		test_backpressure();
		test_random();
		if (tree_q.size() != 0)
			report_mismatch("results outstanding", tree_q.size(), 0);
		if (n_errors == 0)
			$display("** manhattan_kruskal_mst_unit: PASSED **");
		else
			$display("** manhattan_kruskal_mst_unit: FAILED **");
		$finish;
	end

endmodule

### filelist.f
rtl/mkm_pkg.sv
rtl/mkm_store.sv
rtl/mkm_dist.sv
rtl/manhattan_kruskal_mst_unit.sv
verif/tb_manhattan_kruskal_mst_unit.sv
